[hdl/assert_macros.svh]
// assertion macros shared by the allocator rtl
// clocked on clk; the reset-aware form is disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check sampled at every rising clk edge, disabled during reset
`define ASA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check sampled at every rising clk edge, reset included
`define ASA_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/asa_pkg.sv]
// shared types and constants of the aligned stack allocator
// no dependencies
package asa_pkg;

	// fixed field widths
	localparam int OPCODE_W  = 2;
	localparam int DATA_W    = 32;
	localparam int ALIGN_W   = 8;
	localparam int STATUS_W  = 3;
	localparam int LIVE_W    = 7;
	localparam int ADJ_W     = 8;
	localparam int CFG_IDX_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ARENA_SIZE   = 1'b1;

	// register reset values
	localparam logic [DATA_W-1:0] BASE_RESET  = 32'd0;
	localparam logic [DATA_W-1:0] ARENA_RESET = 32'd4096;

	typedef enum logic [OPCODE_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_CLEAR = 2'd2
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_NOSPACE = 3'd1,
		ST_NOTTOP  = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_BAD     = 3'd4,
		ST_FULL    = 3'd5
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} fsm_t;

endpackage

[hdl/asa_if.sv]
// request and response channel interfaces of the allocator
// depends on asa_pkg for field widths
interface asa_req_if import asa_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [OPCODE_W-1:0]   opcode;
	logic [DATA_W-1:0]     request_bytes;
	logic [ALIGN_W-1:0]    alignment;
	logic [DATA_W-1:0]     free_address;

	modport source (output valid, opcode, request_bytes, alignment, free_address,
		input ready);
	modport sink (input valid, opcode, request_bytes, alignment, free_address,
		output ready);
endinterface

interface asa_rsp_if import asa_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [DATA_W-1:0]     granted_address;
	logic [STATUS_W-1:0]   status;
	logic [DATA_W-1:0]     used_bytes;
	logic [DATA_W-1:0]     top_address;
	logic [LIVE_W-1:0]     live_count;

	modport source (output valid, granted_address, status, used_bytes, top_address,
		live_count, input ready);
	modport sink (input valid, granted_address, status, used_bytes, top_address,
		live_count, output ready);
endinterface

[hdl/aligned_stack_allocator.sv]
// aligned stack allocator: lifo arena allocator with alignment headers
// a request is taken in idle while the top record is read; the execute state then loads the result,
// a clear first popping every live block (one pop a cycle)
// a new request is taken only after that load, which waits while the held result is not yet taken
// reset: control state, counters and the arena size register reset at once (free position to base 0, size 4096);
// the record memory is not cleared, an entry is only read after it was pushed
// depends on asa_pkg, asa_if and assert_macros.svh
`include "assert_macros.svh"

module aligned_stack_allocator import asa_pkg::*; #(
	parameter int STACK_DEPTH  = 64,
	parameter int HEADER_BYTES = 16,
	parameter int ADDR_BITS    = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	asa_req_if.sink              req,
	asa_rsp_if.source            rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int REC_W = ADJ_W + ADDR_BITS;
	localparam int CMP_W = (ADDR_BITS > DATA_W) ? ADDR_BITS : DATA_W;
	localparam int SUM_W = DATA_W + 2;
	localparam logic [ADJ_W:0]   HDR_BYTES = (ADJ_W + 1)'(HEADER_BYTES);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

	// configuration register
	logic [DATA_W-1:0]    arena_q;

	// allocator state
	logic [ADDR_BITS-1:0] nfp_q;
	logic [ADDR_BITS-1:0] top_q;
	logic [DATA_W-1:0]    bytes_q;
	logic [CNT_W-1:0]     count_q;
	fsm_t                 state_q;
	fsm_t                 state_d;

	// captured request
	opcode_t              op_s1;
	logic [DATA_W-1:0]    req_s1;
	logic [DATA_W-1:0]    faddr_s1;
	logic [ADJ_W-1:0]     adj_s1;
	logic                 bad_s1;

	// record memory: {adjustment, previous top}
	logic [REC_W-1:0]     rec_mem [STACK_DEPTH];
	logic [REC_W-1:0]     rdata_q;
	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	logic                 wr_en;

	// result register
	logic                 out_valid_q;
	logic [DATA_W-1:0]    out_granted_q;
	status_t              out_status_q;
	logic [DATA_W-1:0]    out_used_q;
	logic [DATA_W-1:0]    out_top_q;
	logic [LIVE_W-1:0]    out_live_q;

	// control
	logic                 in_ready;
	logic                 accept;
	logic                 out_free;
	logic                 out_load;
	logic                 clear_pop;

	// header adjustment of the incoming request
	logic [ALIGN_W-1:0]   align_m1;
	logic [ADJ_W-1:0]     gap;
	logic [ADJ_W:0]       need;
	logic [ADJ_W:0]       rounded;
	logic [ADJ_W:0]       adj_full;
	logic                 bad_in;

	// datapath of the execute cycle
	logic [ADJ_W-1:0]     rd_adj;
	logic [ADDR_BITS-1:0] rd_prev;
	logic [ADDR_BITS-1:0] pop_span;
	logic [SUM_W-1:0]     need_sum;
	logic                 nospace;
	logic [ADDR_BITS-1:0] alloc_addr;
	logic                 alloc_ok;
	logic                 pop_ok;
	logic                 pop_now;
	logic                 alloc_now;
	status_t              res_status;
	logic [ADDR_BITS-1:0] nfp_d;
	logic [ADDR_BITS-1:0] top_d;
	logic [DATA_W-1:0]    bytes_d;
	logic [CNT_W-1:0]     count_d;

	assign accept   = req.valid && in_ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = in_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory read and result load
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = IDX_W'(count_q - CNT_W'(1));
		out_load  = 1'b0;
		clear_pop = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (req.valid) begin
					state_d = S_EXEC;
					rd_en   = (count_q != '0);
				end
			end
			S_EXEC: begin
				if (op_s1 == OP_CLEAR && count_q != '0) begin
					// pop one block and fetch the record below it
					clear_pop = 1'b1;
					rd_en     = (count_q > CNT_W'(1));
					rd_addr   = IDX_W'(count_q - CNT_W'(2));
				end else if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// forward alignment gap grown to hold the header
	always_comb begin
		align_m1 = req.alignment - ALIGN_W'(1);
		gap      = (ADJ_W'(0) - nfp_q[ADJ_W-1:0]) & align_m1;
		need     = HDR_BYTES - {1'b0, gap};
		rounded  = (need + {1'b0, align_m1}) & ~{1'b0, align_m1};
		if ({1'b0, gap} < HDR_BYTES) begin
			adj_full = {1'b0, gap} + rounded;
		end else begin
			adj_full = {1'b0, gap};
		end
		bad_in = (req.request_bytes == '0) || (req.alignment == '0) ||
			((req.alignment & align_m1) != '0);
	end

	// capture the request
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= opcode_t'(req.opcode);
			req_s1   <= req.request_bytes;
			faddr_s1 <= req.free_address;
			adj_s1   <= adj_full[ADJ_W-1:0];
			bad_s1   <= bad_in;
		end
	end

	// record memory ports
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= rec_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rec_mem[IDX_W'(count_q)] <= {adj_s1, top_q};
		end
	end

	// result and state update of the execute cycle
	always_comb begin
		rd_adj     = rdata_q[REC_W-1 -: ADJ_W];
		rd_prev    = rdata_q[ADDR_BITS-1:0];
		pop_span   = nfp_q - top_q;
		need_sum   = SUM_W'(bytes_q) + SUM_W'(adj_s1) + SUM_W'(req_s1);
		nospace    = need_sum > SUM_W'(arena_q);
		alloc_addr = nfp_q + ADDR_BITS'(adj_s1);
		alloc_ok   = 1'b0;
		pop_ok     = 1'b0;
		res_status = ST_OK;
		case (op_s1)
			OP_ALLOC: begin
				if (bad_s1) begin
					res_status = ST_BAD;
				end else if (count_q >= DEPTH_CNT) begin
					res_status = ST_FULL;
				end else if (nospace) begin
					res_status = ST_NOSPACE;
				end else begin
					alloc_ok = 1'b1;
				end
			end
			OP_FREE: begin
				if (count_q == '0) begin
					res_status = ST_EMPTY;
				end else if (CMP_W'(faddr_s1) != CMP_W'(top_q)) begin
					res_status = ST_NOTTOP;
				end else begin
					pop_ok = 1'b1;
				end
			end
			OP_CLEAR: begin
				res_status = ST_OK;
			end
			default: begin
				res_status = ST_BAD;
			end
		endcase
		pop_now   = clear_pop || (out_load && pop_ok);
		alloc_now = out_load && alloc_ok;
		wr_en     = alloc_now;
		nfp_d     = nfp_q;
		top_d     = top_q;
		bytes_d   = bytes_q;
		count_d   = count_q;
		if (pop_now) begin
			nfp_d   = top_q - ADDR_BITS'(rd_adj);
			top_d   = rd_prev;
			bytes_d = bytes_q - DATA_W'(pop_span) - DATA_W'(rd_adj);
			count_d = count_q - CNT_W'(1);
		end else if (alloc_now) begin
			nfp_d   = alloc_addr + ADDR_BITS'(req_s1);
			top_d   = alloc_addr;
			bytes_d = DATA_W'(need_sum);
			count_d = count_q + CNT_W'(1);
		end
		// a base write moves the free position while no block is live
		if (cfg_we && cfg_index == CFG_BASE_ADDRESS && count_q == '0) begin
			nfp_d = ADDR_BITS'(cfg_data);
		end
	end

	// allocator state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_q <= ARENA_RESET;
			nfp_q   <= ADDR_BITS'(BASE_RESET);
			top_q   <= '0;
			bytes_q <= '0;
			count_q <= '0;
		end else begin
			nfp_q   <= nfp_d;
			top_q   <= top_d;
			bytes_q <= bytes_d;
			count_q <= count_d;
			if (cfg_we && cfg_index == CFG_ARENA_SIZE) begin
				arena_q <= cfg_data;
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_granted_q <= alloc_now ? DATA_W'(alloc_addr) : '0;
			out_status_q  <= res_status;
			out_used_q    <= bytes_d;
			out_top_q     <= (count_d != '0) ? DATA_W'(top_d) : '0;
			out_live_q    <= LIVE_W'(count_d);
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.granted_address = out_granted_q;
	assign rsp.status          = out_status_q;
	assign rsp.used_bytes      = out_used_q;
	assign rsp.top_address     = out_top_q;
	assign rsp.live_count      = out_live_q;

	// checks
	`ASA_ASSERT_ALWAYS(a_count_bound, count_q <= DEPTH_CNT, "live count beyond stack depth")
	`ASA_ASSERT(a_clear_empties, (out_load && op_s1 == OP_CLEAR) |=> (rsp.live_count == '0), "clear left live blocks")
	`ASA_ASSERT(a_grant_only_ok, (rsp.valid && rsp.status != ST_OK) |-> (rsp.granted_address == '0), "address granted on a failed request")
	`ASA_ASSERT(a_accept_exec, (req.valid && req.ready) |=> (state_q == S_EXEC), "accepted transaction not executed")
	`ASA_ASSERT(a_mem_port, wr_en |-> !rd_en, "record read and write in the same cycle")

endmodule

[sim/aligned_stack_allocator_tb.sv]
// testbench of the aligned stack allocator: directed and random request streams,
// each result checked field by field against an in-bench model of the arena
// depends on asa_pkg, asa_if (asa_req_if, asa_rsp_if) and aligned_stack_allocator from the rtl
module aligned_stack_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import asa_pkg::*;

	localparam int STACK_DEPTH   = 64;
	localparam int HEADER_BYTES  = 16;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int HOLD_CYCLES   = 300;
	// a clear of a full stack pops one block a cycle
	localparam int SETTLE_CYCLES = STACK_DEPTH + 16;
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [DATA_W-1:0]   request_bytes;
		logic [ALIGN_W-1:0]  alignment;
		logic [DATA_W-1:0]   free_address;
	} alloc_request_t;

	typedef struct packed {
		logic [DATA_W-1:0] granted;
		status_t           status;
		logic [DATA_W-1:0] used;
		logic [DATA_W-1:0] top;
		logic [LIVE_W-1:0] live;
	} alloc_result_t;

	typedef struct packed {
		logic [DATA_W-1:0]                     base;
		logic [DATA_W-1:0]                     arena;
		logic [DATA_W-1:0]                     next_pos;
		logic [DATA_W-1:0]                     top;
		logic [DATA_W-1:0]                     used;
		logic [LIVE_W-1:0]                     count;
		logic [STACK_DEPTH-1:0][ADJ_W-1:0]     adj;
		logic [STACK_DEPTH-1:0][DATA_W-1:0]    prev;
	} arena_state_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_data;

	asa_req_if req_ch ();
	asa_rsp_if rsp_ch ();

	aligned_stack_allocator #(
		.STACK_DEPTH  (STACK_DEPTH),
		.HEADER_BYTES (HEADER_BYTES),
		.ADDR_BITS    (32)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// model state: arena follows accepted transactions, plan follows the queued ones
	arena_state_t    arena;
	arena_state_t    plan;
	alloc_request_t  pending_reqs[$];
	alloc_result_t   results_due[$];
	alloc_request_t  on_bus = '0;
	logic            offering = 1'b0;
	logic            req_taken = 1'b0;
	logic            idle_on = 1'b1;
	logic            hold_request = 1'b0;
	int              send_gap = 0;
	int              stall_left = 0;
	int              hold_left = 0;
	int              cycle_count = 0;
	int              mismatches = 0;

	function automatic arena_state_t reset_state();
		arena_state_t s;
		s = '0;
		s.base = BASE_RESET;
		s.arena = ARENA_RESET;
		s.next_pos = BASE_RESET;
		return s;
	endfunction

	// forward alignment gap, grown by whole steps until a header fits
	function automatic logic [DATA_W-1:0] header_gap(input logic [DATA_W-1:0] pos,
		input logic [ALIGN_W-1:0] align);
		logic [DATA_W-1:0] step;
		logic [DATA_W-1:0] gap;
		step = {24'd0, align};
		gap = (32'd0 - pos) & (step - 32'd1);
		if (gap < HEADER_BYTES)
			gap = gap + ((HEADER_BYTES - gap + step - 32'd1) / step) * step;
		return gap;
	endfunction

	function automatic void pop_block(inout arena_state_t s);
		logic [LIVE_W-1:0] idx;
		idx = s.count - 7'd1;
		s.used = s.used - (s.next_pos - s.top) - {24'd0, s.adj[idx]};
		s.next_pos = s.top - {24'd0, s.adj[idx]};
		s.top = s.prev[idx];
		s.count = idx;
	endfunction

	function automatic void apply_config(inout arena_state_t s,
		input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		case (idx)
			CFG_BASE_ADDRESS: begin
				s.base = value;
				// a new base only moves the position while nothing is live
				if (s.count == 0)
					s.next_pos = value;
			end
			CFG_ARENA_SIZE: s.arena = value;
			default: ;
		endcase
	endfunction

	// allocator behavior for one request transaction
	function automatic alloc_result_t apply_request(inout arena_state_t s,
		input alloc_request_t rq);
		alloc_result_t     res;
		logic [DATA_W-1:0] adj;
		logic [DATA_W-1:0] addr;
		res = '0;
		res.status = ST_OK;
		case (rq.opcode)
			OP_ALLOC: begin
				if (rq.request_bytes == 0 || rq.alignment == 0 ||
					(rq.alignment & (rq.alignment - 8'd1)) != 8'd0)
					res.status = ST_BAD;
				else if (s.count >= STACK_DEPTH)
					res.status = ST_FULL;
				else begin
					adj = header_gap(s.next_pos, rq.alignment);
					if ({32'd0, s.used} + {32'd0, adj} + {32'd0, rq.request_bytes} >
						{32'd0, s.arena})
						res.status = ST_NOSPACE;
					else begin
						addr = s.next_pos + adj;
						s.adj[s.count] = adj[ADJ_W-1:0];
						s.prev[s.count] = s.top;
						s.count = s.count + 7'd1;
						s.top = addr;
						s.next_pos = addr + rq.request_bytes;
						s.used = s.used + adj + rq.request_bytes;
						res.granted = addr;
					end
				end
			end
			OP_FREE: begin
				if (s.count == 0)
					res.status = ST_EMPTY;
				else if (rq.free_address != s.top)
					res.status = ST_NOTTOP;
				else
					pop_block(s);
			end
			OP_CLEAR: begin
				while (s.count > 0)
					pop_block(s);
			end
			default: res.status = ST_BAD;
		endcase
		res.used = s.used;
		res.top = (s.count > 0) ? s.top : '0;
		res.live = s.count;
		return res;
	endfunction

	function automatic alloc_request_t make_req(input logic [OPCODE_W-1:0] op,
		input logic [DATA_W-1:0] bytes, input logic [ALIGN_W-1:0] align,
		input logic [DATA_W-1:0] faddr);
		alloc_request_t r;
		r.opcode = op;
		r.request_bytes = bytes;
		r.alignment = align;
		r.free_address = faddr;
		return r;
	endfunction

	// mostly well-formed allocate/free traffic, some clears and noise
	function automatic alloc_request_t pick_request(input int alloc_pct, input int max_bytes);
		alloc_request_t r;
		int             roll;
		r.opcode = OP_ALLOC;
		r.request_bytes = $urandom;
		r.alignment = ALIGN_W'($urandom_range(0, 255));
		r.free_address = $urandom;
		roll = $urandom_range(0, 99);
		if (roll < alloc_pct) begin
			r.alignment = 8'd1 << $urandom_range(0, 7);
			if ($urandom_range(0, 15) != 0)
				r.request_bytes = $urandom_range(1, max_bytes);
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 60) begin
				r.opcode = OP_FREE;
				r.free_address = plan.top;
			end else if (roll < 75)
				r.opcode = OP_FREE;
			else if (roll < 83)
				r.opcode = OP_CLEAR;
			else begin
				r.opcode = OPCODE_W'($urandom_range(0, 3));
				if ($urandom_range(0, 3) == 0)
					r.request_bytes = '0;
			end
		end
		return r;
	endfunction

	task automatic queue_item(input alloc_request_t r);
		void'(apply_request(plan, r));
		pending_reqs.push_back(r);
	endtask

	task automatic queue_random(input int count, input int alloc_pct, input int max_bytes);
		repeat (count)
			queue_item(pick_request(alloc_pct, max_bytes));
	endtask

	// write both registers back to back, called at a falling edge
	task automatic program_arena(input logic [DATA_W-1:0] base_value,
		input logic [DATA_W-1:0] size_value);
		cfg_we <= 1'b1;
		cfg_index <= CFG_BASE_ADDRESS;
		cfg_data <= base_value;
		@(posedge clk);
		apply_config(arena, CFG_BASE_ADDRESS, base_value);
		@(negedge clk);
		cfg_index <= CFG_ARENA_SIZE;
		cfg_data <= size_value;
		@(posedge clk);
		apply_config(arena, CFG_ARENA_SIZE, size_value);
		@(negedge clk);
		cfg_we <= 1'b0;
		plan = arena;
	endtask

	// wait until every queued transaction has been answered
	task automatic drain();
		while (pending_reqs.size() != 0 || offering || results_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic check_field(input string label, input logic [DATA_W-1:0] want,
		input logic [DATA_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
				$time, label, want, got);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// request driver: holds each transaction until taken, random gaps in between while idle_on is set
	always @(negedge clk) begin
		if (offering && req_taken)
			offering = 1'b0;
		if (!offering) begin
			if (send_gap > 0)
				send_gap--;
			else if (pending_reqs.size() > 0) begin
				if (idle_on && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(0, 7);
				else begin
					on_bus = pending_reqs.pop_front();
					offering = 1'b1;
				end
			end
		end
		req_ch.valid <= offering;
		req_ch.opcode <= on_bus.opcode;
		req_ch.request_bytes <= on_bus.request_bytes;
		req_ch.alignment <= on_bus.alignment;
		req_ch.free_address <= on_bus.free_address;
	end

	// result receiver: random stall bursts while idle_on is set, plus one long hold-off on request
	always @(negedge clk) begin
		logic take;
		take = 1'b0;
		if (hold_left > 0)
			hold_left--;
		else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES - 1;
		end else if (stall_left > 0)
			stall_left--;
		else if (idle_on && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(0, 7);
		else
			take = 1'b1;
		rsp_ch.ready <= take;
	end

	// monitor: check each result transaction, predict each request transaction
	always @(posedge clk) begin
		alloc_result_t  want;
		alloc_request_t seen;
		req_taken <= req_ch.valid && req_ch.ready;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("aligned_stack_allocator_tb NOT OK");
			$finish;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (results_due.size() == 0) begin
					mismatches++;
					$display("%0t: result with none expected, actual status %0d address 0x%08h",
						$time, rsp_ch.status, rsp_ch.granted_address);
				end else begin
					want = results_due.pop_front();
					check_field("granted_address", want.granted, rsp_ch.granted_address);
					check_field("status", DATA_W'(want.status), DATA_W'(rsp_ch.status));
					check_field("used_bytes", want.used, rsp_ch.used_bytes);
					check_field("top_address", want.top, rsp_ch.top_address);
					check_field("live_count", DATA_W'(want.live), DATA_W'(rsp_ch.live_count));
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				seen.opcode = req_ch.opcode;
				seen.request_bytes = req_ch.request_bytes;
				seen.alignment = req_ch.alignment;
				seen.free_address = req_ch.free_address;
				results_due.push_back(apply_request(arena, seen));
			end
		end
	end

	// stimulus phases
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_BASE_ADDRESS;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_ALLOC;
		req_ch.request_bytes = '0;
		req_ch.alignment = '0;
		req_ch.free_address = '0;
		rsp_ch.ready = 1'b0;
		arena = reset_state();
		plan = arena;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part on the reset configuration
		queue_item(make_req(OP_FREE, 32'd0, 8'd0, 32'd0));
		queue_item(make_req(OP_CLEAR, 32'd0, 8'd0, 32'd0));
		queue_item(make_req(OP_ALLOC, 32'd0, 8'd8, 32'd0));
		queue_item(make_req(OP_ALLOC, 32'd8, 8'd0, 32'd0));
		queue_item(make_req(OP_ALLOC, 32'd8, 8'd3, 32'd0));
		queue_item(make_req(OP_ALLOC, 32'd8, 8'hFF, 32'd0));
		queue_item(make_req(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF));
		queue_item(make_req(OP_ALLOC, 32'd1, 8'd1, 32'd0));
		queue_item(make_req(OP_ALLOC, 32'd100, 8'd128, 32'd0));
		queue_item(make_req(OP_ALLOC, 32'd5, 8'd2, 32'd0));
		queue_item(make_req(OP_ALLOC, 32'd7, 8'd4, 32'd0));
		queue_item(make_req(OP_ALLOC, 32'd9, 8'd8, 32'd0));
		queue_item(make_req(OP_ALLOC, 32'd33, 8'd32, 32'd0));
		queue_item(make_req(OP_ALLOC, 32'd3, 8'd64, 32'd0));
		queue_item(make_req(OP_ALLOC, 32'd16, 8'd16, 32'd0));
		queue_item(make_req(OP_FREE, 32'd0, 8'd0, 32'hFFFF_FFFF));
		queue_item(make_req(OP_FREE, 32'd0, 8'd0, plan.top));
		queue_item(make_req(OP_ALLOC, 32'hFFFF_FFFF, 8'd1, 32'd0));
		// request that fills the arena to the last byte, then one more
		queue_item(make_req(OP_ALLOC,
			plan.arena - plan.used - header_gap(plan.next_pos, 8'd16), 8'd16, 32'd0));
		queue_item(make_req(OP_ALLOC, 32'd1, 8'd1, 32'd0));
		queue_item(make_req(OP_CLEAR, 32'd0, 8'd0, 32'd0));
		queue_item(make_req(OP_ALLOC, ARENA_RESET - HEADER_BYTES, 8'd1, 32'd0));
		queue_item(make_req(OP_CLEAR, 32'd0, 8'd0, 32'd0));
		drain();

		// odd base, long hold-off on the result side so the block backs up
		program_arena(32'h1000_0003, 32'd4096);
		queue_random(180, 55, 200);
		hold_request = 1'b1;
		drain();

		// base near the top of the address space, huge arena: stack fills up
		program_arena(32'hFFFF_FF00, 32'hFFFF_FFFF);
		queue_random(160, 85, 64);
		drain();

		// one-byte arena, blocks may still be live from the last phase
		program_arena($urandom, 32'd1);
		queue_random(60, 55, 4);
		drain();

		// all-ones base with large requests
		program_arena(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_random(150, 55, 100000);
		drain();

		// closing stretch without idling
		program_arena($urandom, 32'd4096);
		idle_on = 1'b0;
		queue_random(230, 55, 300);
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (mismatches == 0)
			$display("aligned_stack_allocator_tb OK");
		else
			$display("aligned_stack_allocator_tb NOT OK");
		$finish;
	end

endmodule

[aligned_stack_allocator.f]
+incdir+hdl
hdl/asa_pkg.sv
hdl/asa_if.sv
hdl/aligned_stack_allocator.sv
sim/aligned_stack_allocator_tb.sv
